/* rtl/rfa_pkg.sv */
// Shared types and constants for the rational fraction ALU.
// Used by rfa_addsub, rational_fraction_alu and rfa_checker; no dependencies.
`default_nettype none

package rfa_pkg;

    localparam int RFA_OPERAND_WIDTH = 16;
    localparam int DP_W  = 64;          // datapath width of products and gcd operands
    localparam int ADD_W = DP_W + 1;    // shared adder carries one extra sign bit
    localparam int NUM_W = 34;
    localparam int DEN_W = 33;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DIV0 = 2'd1;
    localparam logic [1:0] STAT_ZDEN = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MLOAD,
        S_MUL,
        S_CMP,
        S_COMB,
        S_NEGN,
        S_NEGD,
        S_ABS,
        S_GCD,
        S_DIV,
        S_FIN
    } state_t;

endpackage

`default_nettype wire

/* rtl/rfa_addsub.sv */
// Shared add/subtract unit of the rational fraction ALU.
// Depends on rfa_pkg for the adder width.
`default_nettype none

module rfa_addsub
    import rfa_pkg::*;
(
    input  wire logic [ADD_W-1:0] a,
    input  wire logic [ADD_W-1:0] b,
    input  wire logic             sub,
    output logic      [ADD_W-1:0] sum
);

    logic [ADD_W-1:0] b_x;

    assign b_x = sub ? ~b : b;
    assign sum = a + b_x + {{(ADD_W-1){1'b0}}, sub};

endmodule

`default_nettype wire

/* rtl/rational_fraction_alu.sv */
// Top level of the rational fraction ALU: sequencer and datapath registers.
// Depends on rfa_pkg and on the shared adder rfa_addsub.
//
// Usage: drive opcode and the four operands and pulse start while busy is
// low; that cycle is the transfer of the item. busy stays high while the
// item is worked on. The result (res_num, res_den, a_greater, status) is
// shown for exactly one cycle with done high; the receiver cannot stall,
// so it must capture it then. A new start is taken in the done cycle.
// The datapath arithmetic goes through one 65-bit adder: the cross products
// are formed by serial shift-add (two to four products, each with a load
// step), the gcd by a binary subtract/shift loop (one step per cycle), and
// the two reducing divisions by a restoring divider. An item with a zero
// denominator goes from idle straight to the result state. The adder is
// used at most once per cycle. Reset returns the sequencer to idle and
// clears done.
`default_nettype none

module rational_fraction_alu
    import rfa_pkg::*;
#(
    parameter int OPERAND_WIDTH = RFA_OPERAND_WIDTH
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [2:0]                      opcode,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_den,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic                                 done,
    output logic signed [NUM_W-1:0]              res_num,
    output logic        [DEN_W-1:0]              res_den,
    output logic                                 a_greater,
    output logic        [1:0]                    status
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    logic [2:0]          op_reg, op_next;
    logic signed [W:0]   an_reg, an_next, ad_reg, ad_next;
    logic signed [W:0]   bn_reg, bn_next, bd_reg, bd_next;
    logic [DP_W-1:0]     p_reg [4];
    logic                p_we;
    logic [DP_W-1:0]     p_wdata;
    logic [1:0]          mi_reg, mi_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DP_W-1:0]     mc_reg, mc_next, acc_reg, acc_next;
    logic [W:0]          mp_reg, mp_next;
    logic [DP_W-1:0]     num_reg, num_next, nd_reg, nd_next;
    logic                neg_reg, neg_next;
    logic [DP_W-1:0]     u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [5:0]          k_reg, k_next, dcnt_reg, dcnt_next;
    logic                dsel_reg, dsel_next;
    logic [DP_W-1:0]     rem_reg, rem_next, quo_reg, quo_next;
    logic [DP_W-1:0]     magq_reg, magq_next, denq_reg, denq_next;
    logic                gt_reg, gt_next;
    logic [1:0]          stat_reg, stat_next;
    logic signed [NUM_W-1:0] res_num_reg, res_num_next;
    logic [DEN_W-1:0]    res_den_reg, res_den_next;
    logic                a_greater_reg, a_greater_next;
    logic [1:0]          status_reg, status_next;

    logic [ADD_W-1:0]    add_a, add_b, add_sum;
    logic                add_sub;

    logic signed [W:0]   an_x, ad_x, bn_x, bd_x;
    logic signed [W:0]   m_a, m_b;
    logic [1:0]          mi_last;
    logic                mul_last;
    logic [ADD_W-1:0]    div_a;
    logic [DP_W-1:0]     quo_step;

    rfa_addsub u_addsub (
        .a   (add_a),
        .b   (add_b),
        .sub (add_sub),
        .sum (add_sum)
    );

    // Denominators are made positive on entry; the sign moves to the numerator.
    always_comb
    begin
        an_x = {a_num[W-1], a_num};
        ad_x = {a_den[W-1], a_den};
        bn_x = {b_num[W-1], b_num};
        bd_x = {b_den[W-1], b_den};
        if (a_den[W-1])
        begin
            an_x = -an_x;
            ad_x = -ad_x;
        end
        if (b_den[W-1])
        begin
            bn_x = -bn_x;
            bd_x = -bd_x;
        end
    end

    // Operands of each product; products 0 and 1 feed the comparison.
    always_comb
    begin
        m_a = ad_reg;
        m_b = bd_reg;
        unique case (mi_reg)
            2'd0:
            begin
                m_a = an_reg;
                m_b = bd_reg;
            end
            2'd1:
            begin
                m_a = bn_reg;
                m_b = ad_reg;
            end
            2'd2:
            begin
                priority if (op_reg == OP_MUL)
                begin
                    m_a = an_reg;
                    m_b = bn_reg;
                end
                else if (op_reg == OP_DIV)
                begin
                    m_a = ad_reg;
                    m_b = bn_reg;
                end
                else
                begin
                    m_a = ad_reg;
                    m_b = bd_reg;
                end
            end
            default:
            begin
                m_a = ad_reg;
                m_b = bd_reg;
            end
        endcase
        priority if (op_reg == OP_MUL)
            mi_last = 2'd3;
        else if (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_DIV)
            mi_last = 2'd2;
        else
            mi_last = 2'd1;
    end

    assign mul_last = (cnt_reg == CNT_W'(W));
    assign div_a    = {rem_reg, quo_reg[DP_W-1]};
    assign quo_step = {quo_reg[DP_W-2:0], ~add_sum[ADD_W-1]};

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        op_next        = op_reg;
        an_next        = an_reg;
        ad_next        = ad_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        p_we           = 1'b0;
        p_wdata        = acc_reg;
        mi_next        = mi_reg;
        cnt_next       = cnt_reg;
        mc_next        = mc_reg;
        mp_next        = mp_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        nd_next        = nd_reg;
        neg_next       = neg_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        g_next         = g_reg;
        k_next         = k_reg;
        dcnt_next      = dcnt_reg;
        dsel_next      = dsel_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        magq_next      = magq_reg;
        denq_next      = denq_reg;
        gt_next        = gt_reg;
        stat_next      = stat_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        a_greater_next = a_greater_reg;
        status_next    = status_reg;
        add_a          = '0;
        add_b          = '0;
        add_sub        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = opcode;
                    an_next = an_x;
                    ad_next = ad_x;
                    bn_next = bn_x;
                    bd_next = bd_x;
                    mi_next = 2'd0;
                    if (a_den == '0 || b_den == '0)
                    begin
                        stat_next  = STAT_ZDEN;
                        gt_next    = 1'b0;
                        neg_next   = 1'b0;
                        magq_next  = '0;
                        denq_next  = DP_W'(1);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        stat_next  = STAT_OK;
                        state_next = S_MLOAD;
                    end
                end
            end
            S_MLOAD:
            begin
                mc_next    = {{(DP_W-W-1){m_a[W]}}, m_a};
                mp_next    = m_b;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // The top multiplier bit carries negative weight.
                add_a   = {1'b0, acc_reg};
                add_b   = {1'b0, mc_reg};
                add_sub = mul_last;
                if (mp_reg[0])
                    acc_next = add_sum[DP_W-1:0];
                mc_next  = {mc_reg[DP_W-2:0], 1'b0};
                mp_next  = {1'b0, mp_reg[W:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (mul_last)
                begin
                    p_we    = 1'b1;
                    p_wdata = mp_reg[0] ? add_sum[DP_W-1:0] : acc_reg;
                    if (mi_reg == mi_last)
                        state_next = S_CMP;
                    else
                    begin
                        mi_next    = mi_reg + 2'd1;
                        state_next = S_MLOAD;
                    end
                end
            end
            S_CMP:
            begin
                add_a      = {p_reg[0][DP_W-1], p_reg[0]};
                add_b      = {p_reg[1][DP_W-1], p_reg[1]};
                add_sub    = 1'b1;
                gt_next    = (add_sum != '0) && !add_sum[ADD_W-1];
                state_next = S_COMB;
            end
            S_COMB:
            begin
                add_a   = {1'b0, p_reg[0]};
                add_b   = {1'b0, p_reg[1]};
                add_sub = (op_reg == OP_SUB);
                unique case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        num_next = add_sum[DP_W-1:0];
                        nd_next  = p_reg[2];
                    end
                    OP_MUL:
                    begin
                        num_next = p_reg[2];
                        nd_next  = p_reg[3];
                    end
                    OP_DIV:
                    begin
                        if (bn_reg == '0)
                        begin
                            stat_next = STAT_DIV0;
                            num_next  = '0;
                            nd_next   = DP_W'(1);
                        end
                        else
                        begin
                            num_next = p_reg[0];
                            nd_next  = p_reg[2];
                        end
                    end
                    default:
                    begin
                        num_next = '0;
                        nd_next  = DP_W'(1);
                    end
                endcase
                state_next = S_NEGN;
            end
            S_NEGN:
            begin
                // Only a quotient by a negative numerator gets a negative denominator.
                add_b   = {1'b0, num_reg};
                add_sub = 1'b1;
                if (nd_reg[DP_W-1])
                begin
                    num_next   = add_sum[DP_W-1:0];
                    state_next = S_NEGD;
                end
                else
                    state_next = S_ABS;
            end
            S_NEGD:
            begin
                add_b      = {1'b0, nd_reg};
                add_sub    = 1'b1;
                nd_next    = add_sum[DP_W-1:0];
                state_next = S_ABS;
            end
            S_ABS:
            begin
                add_b    = {1'b0, num_reg};
                add_sub  = 1'b1;
                neg_next = num_reg[DP_W-1];
                if (num_reg[DP_W-1])
                    num_next = add_sum[DP_W-1:0];
                u_next     = num_reg[DP_W-1] ? add_sum[DP_W-1:0] : num_reg;
                v_next     = nd_reg;
                k_next     = '0;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                add_a   = {1'b0, u_reg};
                add_b   = {1'b0, v_reg};
                add_sub = 1'b1;
                priority if (u_reg == '0)
                begin
                    g_next     = v_reg << k_reg;
                    rem_next   = '0;
                    quo_next   = num_reg;
                    dcnt_next  = '0;
                    dsel_next  = 1'b0;
                    state_next = S_DIV;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 6'd1;
                end
                else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (!add_sum[ADD_W-1])
                    u_next = add_sum[DP_W-1:0];
                else
                begin
                    // Both odd and u below v: swap, the subtraction follows next cycle.
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            S_DIV:
            begin
                add_a     = div_a;
                add_b     = {1'b0, g_reg};
                add_sub   = 1'b1;
                rem_next  = add_sum[ADD_W-1] ? div_a[DP_W-1:0] : add_sum[DP_W-1:0];
                quo_next  = quo_step;
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                begin
                    if (!dsel_reg)
                    begin
                        magq_next = quo_step;
                        rem_next  = '0;
                        quo_next  = nd_reg;
                        dsel_next = 1'b1;
                    end
                    else
                    begin
                        denq_next  = quo_step;
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                add_b          = {1'b0, magq_reg};
                add_sub        = 1'b1;
                res_num_next   = neg_reg ? add_sum[NUM_W-1:0] : magq_reg[NUM_W-1:0];
                res_den_next   = denq_reg[DEN_W-1:0];
                a_greater_next = gt_reg;
                status_next    = stat_reg;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        an_reg        <= an_next;
        ad_reg        <= ad_next;
        bn_reg        <= bn_next;
        bd_reg        <= bd_next;
        if (p_we)
            p_reg[mi_reg] <= p_wdata;
        mi_reg        <= mi_next;
        cnt_reg       <= cnt_next;
        mc_reg        <= mc_next;
        mp_reg        <= mp_next;
        acc_reg       <= acc_next;
        num_reg       <= num_next;
        nd_reg        <= nd_next;
        neg_reg       <= neg_next;
        u_reg         <= u_next;
        v_reg         <= v_next;
        g_reg         <= g_next;
        k_reg         <= k_next;
        dcnt_reg      <= dcnt_next;
        dsel_reg      <= dsel_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        magq_reg      <= magq_next;
        denq_reg      <= denq_next;
        gt_reg        <= gt_next;
        stat_reg      <= stat_next;
        res_num_reg   <= res_num_next;
        res_den_reg   <= res_den_next;
        a_greater_reg <= a_greater_next;
        status_reg    <= status_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign a_greater = a_greater_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

/* rtl/rfa_checker.sv */
// Port-level checks for the rational fraction ALU, bound to the top level.
// Depends on rfa_pkg for widths and status codes.
`default_nettype none

module rfa_checker
    import rfa_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic                    done,
    input wire logic signed [NUM_W-1:0] res_num,
    input wire logic        [DEN_W-1:0] res_den,
    input wire logic                    a_greater,
    input wire logic        [1:0]       status
);

    // An accepted transfer always makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // A result is shown only once the block has gone idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result shown while busy or without work");

    // The reduced denominator is never zero and the status is a known code.
    a_den_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> res_den != '0 && status != 2'd3)
        else $error("zero denominator or bad status in result");

    // A zero input denominator gives 0/1 and no ordering.
    a_zden_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_ZDEN |-> res_num == '0 && res_den == DEN_W'(1) && !a_greater)
        else $error("zero denominator result is not 0/1");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (.*);

`default_nettype wire
